FILE: rtl/core/integer_matrix_multiply_core_macros.svh
// Assertion helpers for the core module.
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define IMM_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define IMM_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

FILE: rtl/core/imm_pkg.sv
package imm_pkg;

  localparam int MATRIX_DIM  = 8;
  localparam int INDEX_REACH = 8;
  localparam int STORE_DEPTH = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 3;
  localparam int SIZE_W      = 4;
  localparam int ELEM_W      = 16;
  localparam int MUL_W       = 2 * ELEM_W;
  localparam int PROD_W      = 35;
  localparam int EFF_CAP     = (MATRIX_DIM < INDEX_REACH) ? MATRIX_DIM : INDEX_REACH;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Sideband that travels with each memory read through the pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             row_last;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

FILE: rtl/core/integer_matrix_multiply_core.sv
// Integer matrix multiply core.
// Input channel (in_valid / in_stall) carries one transaction per item:
//   action 0 writes element_value into A[row_index][col_index], action 1 into
//   B; action 2 computes result row row_index; action 3 is dropped.
// Output channel (out_valid / out_stall) carries one result element per
//   transaction: product_value = sum over k of A[row][k]*B[k][col], 35-bit
//   signed, with out_row, out_col and row_last on the final column.
// cfg_wr_en / cfg_wr_data set active_size (reset 8, used up to 8); write it
//   only while the core is idle.
// Sequencing: a compute of size s issues s reads of the A and B memories per
//   column (one read port each, one multiply-accumulate per cycle), then
//   drains the read and multiply registers into the accumulator. in_stall
//   stays high until the last column has been accumulated.
// A column starts only when the output register is empty or being taken, so
//   a stalled receiver holds the sequencer at the next column boundary.
// Reset clears the sequencer, pipeline valids and output valid; the matrix
//   memories are not cleared and must be written before use.
`include "integer_matrix_multiply_core_macros.svh"

module integer_matrix_multiply_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [imm_pkg::SIZE_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic [imm_pkg::IDX_W-1:0]            row_index,
  input  logic [imm_pkg::IDX_W-1:0]            col_index,
  input  logic signed [imm_pkg::ELEM_W-1:0]    element_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [imm_pkg::PROD_W-1:0]    product_value,
  output logic [imm_pkg::IDX_W-1:0]            out_row,
  output logic [imm_pkg::IDX_W-1:0]            out_col,
  output logic                                 row_last
);

  // Operand memories, row-major.
  logic signed [imm_pkg::ELEM_W-1:0] mem_a [imm_pkg::STORE_DEPTH];
  logic signed [imm_pkg::ELEM_W-1:0] mem_b [imm_pkg::STORE_DEPTH];

  logic [imm_pkg::SIZE_W-1:0] active_size;
  logic [imm_pkg::SIZE_W-1:0] eff_size;
  logic [imm_pkg::SIZE_W-1:0] eff_last;

  imm_pkg::state_t state;
  logic [imm_pkg::IDX_W-1:0] cur_row;
  logic [imm_pkg::IDX_W-1:0] col_cnt;
  logic [imm_pkg::IDX_W-1:0] k_cnt;

  logic in_accept;
  logic wr_ok;
  logic [imm_pkg::ADDR_W-1:0] wr_addr;
  logic [imm_pkg::ADDR_W-1:0] a_addr;
  logic [imm_pkg::ADDR_W-1:0] b_addr;
  logic out_free;
  logic issue;
  logic k_last;
  logic j_last;

  imm_pkg::tag_t rd_tag;
  imm_pkg::tag_t mul_tag;
  logic signed [imm_pkg::ELEM_W-1:0] a_rd;
  logic signed [imm_pkg::ELEM_W-1:0] b_rd;
  logic signed [imm_pkg::MUL_W-1:0]  mul_prod;
  logic signed [imm_pkg::PROD_W-1:0] acc;
  logic signed [imm_pkg::PROD_W-1:0] acc_next;
  logic col_done;

  // Saturate the configured size to what the store and index fields reach.
  assign eff_size = (active_size > imm_pkg::SIZE_W'(imm_pkg::EFF_CAP)) ?
                    imm_pkg::SIZE_W'(imm_pkg::EFF_CAP) : active_size;
  assign eff_last = eff_size - imm_pkg::SIZE_W'(1);

  assign in_stall  = (state != imm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign wr_ok   = (int'(row_index) < imm_pkg::MATRIX_DIM) &&
                   (int'(col_index) < imm_pkg::MATRIX_DIM);
  assign wr_addr = imm_pkg::ADDR_W'(int'(row_index) * imm_pkg::MATRIX_DIM + int'(col_index));
  assign a_addr  = imm_pkg::ADDR_W'(int'(cur_row) * imm_pkg::MATRIX_DIM + int'(k_cnt));
  assign b_addr  = imm_pkg::ADDR_W'(int'(k_cnt) * imm_pkg::MATRIX_DIM + int'(col_cnt));

  // Start a column only when the output slot is empty or draining now.
  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == imm_pkg::ST_ISSUE) && ((k_cnt != '0) || out_free);
  assign k_last   = ({1'b0, k_cnt} == eff_last);
  assign j_last   = ({1'b0, col_cnt} == eff_last);
  assign col_done = mul_tag.valid && mul_tag.last;

  assign acc_next = (mul_tag.first ? '0 : acc) + imm_pkg::PROD_W'(mul_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= imm_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      active_size <= cfg_wr_data;
    end
  end

  // Memory writes occur only while idle; only reads made while issuing are used,
  // so the busy stall is the interlock between them.
  always_ff @(posedge clk) begin
    if (in_accept && wr_ok && (action == imm_pkg::ACT_WRITE_A)) begin
      mem_a[wr_addr] <= element_value;
    end
    if (in_accept && wr_ok && (action == imm_pkg::ACT_WRITE_B)) begin
      mem_b[wr_addr] <= element_value;
    end
    a_rd <= mem_a[a_addr];
    b_rd <= mem_b[b_addr];
  end

  // Sequencer: walk columns, and k within each column.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= imm_pkg::ST_IDLE;
      col_cnt <= '0;
      k_cnt   <= '0;
    end else begin
      unique case (state)
        imm_pkg::ST_IDLE: begin
          col_cnt <= '0;
          k_cnt   <= '0;
          if (in_accept && (action == imm_pkg::ACT_COMPUTE) &&
              ({1'b0, row_index} < eff_size)) begin
            state <= imm_pkg::ST_ISSUE;
          end
        end
        imm_pkg::ST_ISSUE: begin
          if (issue) begin
            if (k_last) begin
              k_cnt <= '0;
              state <= imm_pkg::ST_DRAIN;
            end else begin
              k_cnt <= k_cnt + imm_pkg::IDX_W'(1);
            end
          end
        end
        imm_pkg::ST_DRAIN: begin
          if (col_done) begin
            if (mul_tag.row_last) begin
              state <= imm_pkg::ST_IDLE;
            end else begin
              col_cnt <= col_cnt + imm_pkg::IDX_W'(1);
              state   <= imm_pkg::ST_ISSUE;
            end
          end
        end
        default: state <= imm_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (action == imm_pkg::ACT_COMPUTE)) begin
      cur_row <= row_index;
    end
  end

  // Read tag, multiply, accumulate; column sums land in the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag.valid  <= 1'b0;
      mul_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid  <= issue;
      mul_tag.valid <= rd_tag.valid;
    end
    rd_tag.first    <= (k_cnt == '0);
    rd_tag.last     <= k_last;
    rd_tag.row_last <= j_last;
    rd_tag.col      <= col_cnt;
    mul_tag.first    <= rd_tag.first;
    mul_tag.last     <= rd_tag.last;
    mul_tag.row_last <= rd_tag.row_last;
    mul_tag.col      <= rd_tag.col;
    mul_prod         <= a_rd * b_rd;
    if (mul_tag.valid) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (col_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (col_done) begin
      product_value <= acc_next;
      out_row       <= cur_row;
      out_col       <= mul_tag.col;
      row_last      <= mul_tag.row_last;
    end
  end

  `IMM_ASSERT_NOW(a_no_overwrite, col_done, !out_valid,
                  "column result would overwrite a waiting result")
  `IMM_ASSERT_NOW(a_pipe_empty_on_accept, in_accept, !rd_tag.valid && !mul_tag.valid,
                  "transaction accepted while reads are in flight")
  `IMM_ASSERT_NOW(a_out_from_acc, $rose(out_valid), $past(col_done),
                  "result appeared without a finished column")

endmodule

FILE: verif/tb_integer_matrix_multiply_core.sv
`timescale 1ns / 1ps

module tb_integer_matrix_multiply_core;

  // Run limit in clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let pass once the last result has been taken.
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic signed [imm_pkg::PROD_W-1:0] product;
    logic [imm_pkg::IDX_W-1:0]         row;
    logic [imm_pkg::IDX_W-1:0]         col;
    logic                              last;
  } row_result_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_wr_en;
  logic [imm_pkg::SIZE_W-1:0]        cfg_wr_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [1:0]                        action;
  logic [imm_pkg::IDX_W-1:0]         row_index;
  logic [imm_pkg::IDX_W-1:0]         col_index;
  logic signed [imm_pkg::ELEM_W-1:0] element_value;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [imm_pkg::PROD_W-1:0] product_value;
  logic [imm_pkg::IDX_W-1:0]         out_row;
  logic [imm_pkg::IDX_W-1:0]         out_col;
  logic                              row_last;

  // Shadow copy of the operand stores and the size register.
  logic signed [imm_pkg::ELEM_W-1:0] a_shadow [imm_pkg::MATRIX_DIM][imm_pkg::MATRIX_DIM];
  logic signed [imm_pkg::ELEM_W-1:0] b_shadow [imm_pkg::MATRIX_DIM][imm_pkg::MATRIX_DIM];
  logic [imm_pkg::SIZE_W-1:0]        size_shadow;

  // Result elements predicted but not yet seen on the output channel.
  row_result_t                pending_products [$];

  int                         fail_count = 0;
  int                         cycle_count = 0;
  bit                         src_idle_on = 1'b1;
  bit                         sink_idle_on = 1'b1;
  int                         sink_hold_len = 0;

  integer_matrix_multiply_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .row_last      (row_last)
  );

  always #2 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** integer_matrix_multiply_core: FAILED **");
      $finish;
    end
  end

  // Size in use: the register, saturated to what the store and indexes reach.
  function automatic int current_size();
    return (int'(size_shadow) > imm_pkg::EFF_CAP) ? imm_pkg::EFF_CAP : int'(size_shadow);
  endfunction

  // Mostly random values, with the two extremes drawn often.
  function automatic logic signed [imm_pkg::ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      default: return imm_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // Update the shadow stores for one accepted transaction and queue the row
  // of dot products that a compute produces.
  task automatic apply_transaction(input imm_pkg::action_t act,
                                   input logic [imm_pkg::IDX_W-1:0] r,
                                   input logic [imm_pkg::IDX_W-1:0] c,
                                   input logic signed [imm_pkg::ELEM_W-1:0] v);
    int n;
    longint acc;
    row_result_t res;
    n = current_size();
    case (act)
      imm_pkg::ACT_WRITE_A: a_shadow[r][c] = v;
      imm_pkg::ACT_WRITE_B: b_shadow[r][c] = v;
      imm_pkg::ACT_COMPUTE: begin
        // A row at or beyond the size in use produces nothing.
        if (int'(r) < n) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
              acc += longint'(a_shadow[r][k]) * longint'(b_shadow[k][j]);
            res.product = acc[imm_pkg::PROD_W-1:0];
            res.row     = r;
            res.col     = imm_pkg::IDX_W'(j);
            res.last    = (j == n - 1);
            pending_products.push_back(res);
          end
        end
      end
      default: ;  // unused action: drop
    endcase
  endtask

  // Offer one transaction after a random gap and hold it until accepted.
  // Valid stays high after acceptance so back-to-back items need no re-raise.
  task automatic send_item(input imm_pkg::action_t act,
                           input logic [imm_pkg::IDX_W-1:0] r,
                           input logic [imm_pkg::IDX_W-1:0] c,
                           input logic signed [imm_pkg::ELEM_W-1:0] v);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action        <= act;
    row_index     <= r;
    col_index     <= c;
    element_value <= v;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_transaction(act, r, c, v);
  endtask

  // Drop valid and wait until every predicted result has been taken, then
  // give the core time to finish any compute that produces no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write active_size; only called with the core idle.
  task automatic set_active_size(input logic [imm_pkg::SIZE_W-1:0] sz);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_shadow = sz;
  endtask

  // Random compute (row mostly below the size), write, or unused transaction.
  // Only called once every store entry has been written.
  task automatic send_random_item();
    int sel;
    int n;
    logic [imm_pkg::IDX_W-1:0] r;
    sel = $urandom_range(0, 19);
    n = current_size();
    if (sel < 11) begin
      if (sel < 9 && n > 0) r = imm_pkg::IDX_W'($urandom_range(0, n - 1));
      else r = imm_pkg::IDX_W'($urandom_range(0, 7));
      send_item(imm_pkg::ACT_COMPUTE, r, imm_pkg::IDX_W'($urandom),
                imm_pkg::ELEM_W'($urandom));
    end else if (sel < 18) begin
      send_item(sel[0] ? imm_pkg::ACT_WRITE_B : imm_pkg::ACT_WRITE_A,
                imm_pkg::IDX_W'($urandom), imm_pkg::IDX_W'($urandom), pick_element());
    end else begin
      send_item(imm_pkg::ACT_UNUSED, imm_pkg::IDX_W'($urandom), imm_pkg::IDX_W'($urandom),
                imm_pkg::ELEM_W'($urandom));
    end
  endtask

  // Corner cases at sizes 1, 2 and 0, touching only entries already written.
  task automatic test_directed_corners();
    set_active_size(4'd1);
    send_item(imm_pkg::ACT_WRITE_A, 3'd0, 3'd0, -16'sd32768);
    send_item(imm_pkg::ACT_WRITE_B, 3'd0, 3'd0, -16'sd32768);
    send_item(imm_pkg::ACT_COMPUTE, 3'd0, 3'd7, 16'sd32767);   // largest single product
    send_item(imm_pkg::ACT_COMPUTE, 3'd1, 3'd0, 16'sd0);       // row beyond size
    send_item(imm_pkg::ACT_UNUSED,  3'd0, 3'd0, 16'sd1234);    // must not touch A
    send_item(imm_pkg::ACT_WRITE_A, 3'd0, 3'd0, 16'sd32767);
    send_item(imm_pkg::ACT_COMPUTE, 3'd0, 3'd0, 16'sd0);
    send_item(imm_pkg::ACT_COMPUTE, 3'd7, 3'd7, -16'sd1);      // row beyond size

    set_active_size(4'd2);
    send_item(imm_pkg::ACT_WRITE_A, 3'd0, 3'd1, 16'sd32767);
    send_item(imm_pkg::ACT_WRITE_A, 3'd1, 3'd0, -16'sd32768);
    send_item(imm_pkg::ACT_WRITE_A, 3'd1, 3'd1, -16'sd1);
    send_item(imm_pkg::ACT_WRITE_B, 3'd0, 3'd1, -16'sd32768);
    send_item(imm_pkg::ACT_WRITE_B, 3'd1, 3'd0, 16'sd32767);
    send_item(imm_pkg::ACT_WRITE_B, 3'd1, 3'd1, -16'sd32768);
    send_item(imm_pkg::ACT_COMPUTE, 3'd0, 3'd5, 16'sd0);
    send_item(imm_pkg::ACT_COMPUTE, 3'd1, 3'd0, -16'sd32768);
    send_item(imm_pkg::ACT_COMPUTE, 3'd7, 3'd0, 16'sd0);

    // Size zero: no compute produces anything.
    set_active_size(4'd0);
    send_item(imm_pkg::ACT_COMPUTE, 3'd0, 3'd0, 16'sd0);
    send_item(imm_pkg::ACT_COMPUTE, 3'd1, 3'd3, 16'sd0);
  endtask

  // Write every entry of both stores so any compute afterwards is legal.
  task automatic test_fill_stores();
    set_active_size(4'd8);
    for (int r = 0; r < imm_pkg::MATRIX_DIM; r++)
      for (int c = 0; c < imm_pkg::MATRIX_DIM; c++)
        send_item(imm_pkg::ACT_WRITE_A, imm_pkg::IDX_W'(r), imm_pkg::IDX_W'(c),
                  pick_element());
    for (int r = 0; r < imm_pkg::MATRIX_DIM; r++)
      for (int c = 0; c < imm_pkg::MATRIX_DIM; c++)
        send_item(imm_pkg::ACT_WRITE_B, imm_pkg::IDX_W'(r), imm_pkg::IDX_W'(c),
                  pick_element());
    send_item(imm_pkg::ACT_COMPUTE, 3'd0, 3'd0, 16'sd0);
    send_item(imm_pkg::ACT_COMPUTE, 3'd7, 3'd7, 16'sd0);
  endtask

  // Random traffic across several sizes, including one that saturates.
  task automatic test_size_sweep();
    int sizes [7] = '{8, 3, 1, 15, 5, 2, 8};
    for (int p = 0; p < 7; p++) begin
      set_active_size(imm_pkg::SIZE_W'(sizes[p]));
      // Run some phases with one side never idling.
      src_idle_on  = (p % 3) != 1;
      sink_idle_on = (p % 4) != 2;
      repeat (3) send_random_item();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Hold the output off long enough that the core fills and stalls its input
  // while computes keep being offered.
  task automatic test_output_backpressure();
    set_active_size(4'd8);
    src_idle_on   = 1'b0;
    sink_hold_len = 400;
    repeat (5) send_item(imm_pkg::ACT_COMPUTE, imm_pkg::IDX_W'($urandom),
                         imm_pkg::IDX_W'($urandom), imm_pkg::ELEM_W'($urandom));
    src_idle_on = 1'b1;
    wait_drained();
  endtask

  // Burst without idling, pause until all results are in, then resume.
  task automatic test_burst_and_pause();
    set_active_size(4'd4);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (5) send_random_item();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    // Let valid be seen low before offering again.
    @(posedge clk);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (5) send_random_item();
  endtask

  // Output stall: draw a stall length per result; a requested hold-off
  // overrides the draw and is counted out here.
  initial begin : result_stall_driver
    int gap;
    forever begin
      gap = sink_idle_on ? $urandom_range(0, 10) : 0;
      if (sink_hold_len > 0) begin
        gap = sink_hold_len;
        sink_hold_len = 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && sink_hold_len == 0);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    row_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_products.size() == 0) begin
        $error("unexpected result: row %0d col %0d product %0d",
               out_row, out_col, product_value);
        fail_count++;
      end else begin
        want = pending_products.pop_front();
        if (product_value !== want.product) begin
          $error("product_value: expected %0d, got %0d", want.product, product_value);
          fail_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          fail_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          fail_count++;
        end
        if (row_last !== want.last) begin
          $error("row_last: expected %0b, got %0b", want.last, row_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    action        <= imm_pkg::ACT_WRITE_A;
    row_index     <= '0;
    col_index     <= '0;
    element_value <= '0;
    size_shadow   = imm_pkg::SIZE_RESET;
    for (int r = 0; r < imm_pkg::MATRIX_DIM; r++)
      for (int c = 0; c < imm_pkg::MATRIX_DIM; c++) begin
        a_shadow[r][c] = '0;
        b_shadow[r][c] = '0;
      end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_fill_stores();
    test_size_sweep();
    test_output_backpressure();
    test_burst_and_pause();

    // Drain and let the last compute settle before judging the run.
    wait_drained();
    if (fail_count == 0) begin
      $display("** integer_matrix_multiply_core: PASSED **");
    end else begin
      $display("** integer_matrix_multiply_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: integer_matrix_multiply_core.f
+incdir+rtl/core
rtl/core/imm_pkg.sv
rtl/core/integer_matrix_multiply_core.sv
verif/tb_integer_matrix_multiply_core.sv
